/* rtl/core/modbus_rtu_master_transaction_assert.svh */
// ----------------------------------------------------------------------------
// Modbus RTU master assertion macros
// Concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_MASTER_TRANSACTION_ASSERT_SVH
`define MODBUS_RTU_MASTER_TRANSACTION_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define MB_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("modbus rtu master check failed");

// Next-cycle implication, disabled in reset.
`define MB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("modbus rtu master check failed");

`endif

/* rtl/core/mbrtu_pkg.sv */
// ----------------------------------------------------------------------------
// Modbus RTU master package
// Types and codes shared by the transaction block, CRC unit and checker.
// ----------------------------------------------------------------------------
`default_nettype none

package mbrtu_pkg;

  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_BYTE  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_STATUS = 2'd1;
  localparam logic [1:0] KIND_WORD   = 2'd2;

  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_TIMEOUT  = 3'd1;
  localparam logic [2:0] STAT_BADFRAME = 3'd2;
  localparam logic [2:0] STAT_CRC      = 3'd3;
  localparam logic [2:0] STAT_EXC      = 3'd4;
  localparam logic [2:0] STAT_BADARG   = 3'd5;

  localparam logic [7:0]  FC_READ     = 8'h04;
  localparam logic [7:0]  FC_WRITE    = 8'h06;
  localparam logic [7:0]  FC_EXC_BIT  = 8'h80;
  localparam logic [15:0] CRC_SEED    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam logic [15:0] TIMEOUT_RST = 16'd500;
  localparam logic [15:0] WAIT_MAX    = 16'hFFFF;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TX_BYTE,
    S_TX_LO,
    S_TX_HI,
    S_RX_CRC,
    S_STATUS,
    S_WORD_RD,
    S_WORD_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_RHDR,
    PH_RBODY,
    PH_WECHO
  } phase_t;

  typedef struct packed {
    logic       init;
    logic       add;
    logic [7:0] data;
  } crc_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/mbrtu_crc.sv */
// ----------------------------------------------------------------------------
// Modbus RTU CRC unit
// Bit-serial CRC-16/MODBUS accumulator, one bit per cycle, eight steps per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrtu_crc
  import mbrtu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire crc_cmd_t    cmd,
  output logic             busy,
  output logic [15:0]      crc
);

  logic [2:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      crc  <= CRC_SEED;
    end else if (busy) begin
      crc  <= crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
      cnt  <= cnt + 3'd1;
      busy <= (cnt != 3'd7);
    end else if (cmd.init) begin
      crc <= CRC_SEED;
    end else if (cmd.add) begin
      crc  <= crc ^ {8'h00, cmd.data};
      cnt  <= '0;
      busy <= 1'b1;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/modbus_rtu_master_transaction.sv */
// ----------------------------------------------------------------------------
// Modbus RTU master transaction
// Builds FC04/FC06 requests, checks replies and echoes, emits register words.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  in       | in_valid / in_ready  | req_type slave_addr func_write reg_addr
//           |                      | word_value rx_byte
//  out      | out_valid / out_ready| out_kind tx_byte status exception_code
//           |                      | reg_word reg_index last
//  cfg      | cfg_we               | cfg_data (response timeout)
//
// A received header, body or echo byte waits in S_RX_CRC while the CRC unit runs 8 steps.
// A start emits the six request bytes, each folded into the CRC, then CRC lo and hi.
// A good read reply then emits its words, each after a registered store read.
// Ticks and idle bytes keep the state in S_IDLE; a result-only item passes S_STATUS.
// Reset is synchronous; out_ready low stalls emission, no beat is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_master_transaction
  import mbrtu_pkg::*;
#(
  parameter int MAX_QTY = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  req_type,
  input  wire logic [7:0]  slave_addr,
  input  wire logic        func_write,
  input  wire logic [15:0] reg_addr,
  input  wire logic [15:0] word_value,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic [7:0]       tx_byte,
  output logic [2:0]       status,
  output logic [7:0]       exception_code,
  output logic [15:0]      reg_word,
  output logic [3:0]       reg_index,
  output logic             last,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_data
);

  localparam int AW = (MAX_QTY > 1) ? $clog2(MAX_QTY) : 1;

  state_t      state, state_next;
  phase_t      phase, phase_next;
  logic [7:0]  rq [0:5];
  logic [7:0]  qty, qty_next;
  logic [7:0]  rx_count, rx_count_next;
  logic [7:0]  crc_lo, crc_lo_next;
  logic [15:0] wait_cnt, wait_cnt_next;
  logic [7:0]  hdr_id, hdr_id_next;
  logic [7:0]  hdr_fc, hdr_fc_next;
  logic [7:0]  hold_hi, hold_hi_next;
  logic        echo_bad, echo_bad_next;
  logic [2:0]  tx_idx, tx_idx_next;
  logic        pend_valid, pend_valid_next;
  logic [2:0]  pend_status, pend_status_next;
  logic [7:0]  pend_exc, pend_exc_next;
  logic        pend_words, pend_words_next;
  logic [7:0]  widx, widx_next;
  logic [15:0] resp_limit;
  logic [15:0] store [0:MAX_QTY-1];
  logic [15:0] rdata;

  logic        load_req, rotate, store_we, emit;
  logic [1:0]  e_kind;
  logic [7:0]  e_tx;
  logic [2:0]  e_status;
  logic [7:0]  e_exc;
  logic [15:0] e_word;
  logic [3:0]  e_idx;
  logic        e_last;
  logic        slot_free;
  logic [7:0]  bc;
  logic [15:0] wc_inc;
  crc_cmd_t    cmd;
  logic        crc_busy;
  logic [15:0] crc;

  mbrtu_crc u_crc (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .busy (crc_busy),
    .crc  (crc)
  );

  assign slot_free = !out_valid || out_ready;
  assign bc        = {qty[6:0], 1'b0};
  assign wc_inc    = (wait_cnt != WAIT_MAX) ? wait_cnt + 16'd1 : wait_cnt;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    state_next       = state;
    phase_next       = phase;
    qty_next         = qty;
    rx_count_next    = rx_count;
    crc_lo_next      = crc_lo;
    wait_cnt_next    = wait_cnt;
    hdr_id_next      = hdr_id;
    hdr_fc_next      = hdr_fc;
    hold_hi_next     = hold_hi;
    echo_bad_next    = echo_bad;
    tx_idx_next      = tx_idx;
    pend_valid_next  = pend_valid;
    pend_status_next = pend_status;
    pend_exc_next    = pend_exc;
    pend_words_next  = pend_words;
    widx_next        = widx;
    load_req         = 1'b0;
    rotate           = 1'b0;
    store_we         = 1'b0;
    emit             = 1'b0;
    e_kind           = KIND_TX;
    e_tx             = '0;
    e_status         = STAT_OK;
    e_exc            = '0;
    e_word           = '0;
    e_idx            = '0;
    e_last           = 1'b0;
    cmd              = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (req_type)
            REQ_START: begin
              phase_next = PH_IDLE;
              if (!func_write && (word_value == 16'd0 || word_value > 16'(MAX_QTY))) begin
                pend_status_next = STAT_BADARG;
                pend_exc_next    = '0;
                pend_words_next  = 1'b0;
                state_next       = S_STATUS;
              end else begin
                load_req      = 1'b1;
                cmd.init      = 1'b1;
                tx_idx_next   = '0;
                qty_next      = func_write ? 8'd0 : word_value[7:0];
                rx_count_next = '0;
                crc_lo_next   = '0;
                wait_cnt_next = '0;
                echo_bad_next = 1'b0;
                state_next    = S_TX_BYTE;
              end
            end
            REQ_BYTE: begin
              case (phase)
                PH_RHDR: begin
                  cmd.add    = 1'b1;
                  cmd.data   = rx_byte;
                  state_next = S_RX_CRC;
                  if (rx_count == 8'd0) begin
                    hdr_id_next   = rx_byte;
                    rx_count_next = 8'd1;
                  end else if (rx_count == 8'd1) begin
                    hdr_fc_next   = rx_byte;
                    rx_count_next = 8'd2;
                  end else if (hdr_id != rq[0] || (hdr_fc & FC_EXC_BIT) != 8'h00 ||
                               hdr_fc != FC_READ || rx_byte != bc) begin
                    phase_next       = PH_IDLE;
                    pend_valid_next  = 1'b1;
                    pend_words_next  = 1'b0;
                    pend_exc_next    = '0;
                    pend_status_next = STAT_BADFRAME;
                    if (hdr_id == rq[0] && (hdr_fc & FC_EXC_BIT) != 8'h00) begin
                      pend_status_next = STAT_EXC;
                      pend_exc_next    = rx_byte;
                    end
                  end else begin
                    phase_next    = PH_RBODY;
                    rx_count_next = '0;
                    wait_cnt_next = '0;
                  end
                end
                PH_RBODY: begin
                  if (rx_count < bc) begin
                    cmd.add       = 1'b1;
                    cmd.data      = rx_byte;
                    store_we      = rx_count[0];
                    hold_hi_next  = rx_count[0] ? hold_hi : rx_byte;
                    rx_count_next = rx_count + 8'd1;
                    state_next    = S_RX_CRC;
                  end else if (rx_count == bc) begin
                    crc_lo_next   = rx_byte;
                    rx_count_next = rx_count + 8'd1;
                  end else begin
                    phase_next       = PH_IDLE;
                    pend_exc_next    = '0;
                    state_next       = S_STATUS;
                    if ({rx_byte, crc_lo} != crc) begin
                      pend_status_next = STAT_CRC;
                      pend_words_next  = 1'b0;
                    end else begin
                      pend_status_next = STAT_OK;
                      pend_words_next  = 1'b1;
                    end
                  end
                end
                PH_WECHO: begin
                  if (rx_count < 8'd6) begin
                    cmd.add       = 1'b1;
                    cmd.data      = rx_byte;
                    rotate        = 1'b1;
                    echo_bad_next = echo_bad || (rx_byte != rq[0]);
                    rx_count_next = rx_count + 8'd1;
                    state_next    = S_RX_CRC;
                  end else if (rx_count == 8'd6) begin
                    crc_lo_next   = rx_byte;
                    rx_count_next = 8'd7;
                  end else begin
                    phase_next      = PH_IDLE;
                    pend_exc_next   = '0;
                    pend_words_next = 1'b0;
                    state_next      = S_STATUS;
                    if ({rx_byte, crc_lo} != crc) begin
                      pend_status_next = STAT_CRC;
                    end else begin
                      pend_status_next = echo_bad ? STAT_BADFRAME : STAT_OK;
                    end
                  end
                end
                default: begin
                end
              endcase
            end
            REQ_TICK: begin
              if (phase != PH_IDLE) begin
                wait_cnt_next = wc_inc;
                if (wc_inc >= resp_limit) begin
                  phase_next       = PH_IDLE;
                  pend_status_next = STAT_TIMEOUT;
                  pend_exc_next    = '0;
                  pend_words_next  = 1'b0;
                  state_next       = S_STATUS;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_TX_BYTE: begin
        if (!crc_busy && slot_free) begin
          emit        = 1'b1;
          e_kind      = KIND_TX;
          e_tx        = rq[0];
          cmd.add     = 1'b1;
          cmd.data    = rq[0];
          rotate      = 1'b1;
          tx_idx_next = tx_idx + 3'd1;
          if (tx_idx == 3'd5) begin
            state_next = S_TX_LO;
          end
        end
      end
      S_TX_LO: begin
        if (!crc_busy && slot_free) begin
          emit       = 1'b1;
          e_kind     = KIND_TX;
          e_tx       = crc[7:0];
          state_next = S_TX_HI;
        end
      end
      S_TX_HI: begin
        if (slot_free) begin
          emit       = 1'b1;
          e_kind     = KIND_TX;
          e_tx       = crc[15:8];
          e_last     = 1'b1;
          cmd.init   = 1'b1;
          phase_next = (rq[1] == FC_WRITE) ? PH_WECHO : PH_RHDR;
          state_next = S_IDLE;
        end
      end
      S_RX_CRC: begin
        if (!crc_busy) begin
          state_next = pend_valid ? S_STATUS : S_IDLE;
        end
      end
      S_STATUS: begin
        if (slot_free) begin
          emit            = 1'b1;
          e_kind          = KIND_STATUS;
          e_status        = pend_status;
          e_exc           = pend_exc;
          e_last          = !pend_words;
          pend_valid_next = 1'b0;
          widx_next       = '0;
          state_next      = pend_words ? S_WORD_RD : S_IDLE;
        end
      end
      S_WORD_RD: begin
        state_next = S_WORD_OUT;
      end
      S_WORD_OUT: begin
        if (slot_free) begin
          emit       = 1'b1;
          e_kind     = KIND_WORD;
          e_word     = rdata;
          e_idx      = widx[3:0];
          e_last     = (widx == qty - 8'd1);
          widx_next  = widx + 8'd1;
          state_next = e_last ? S_IDLE : S_WORD_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= PH_IDLE;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      resp_limit <= TIMEOUT_RST;
      qty        <= '0;
      rx_count   <= '0;
      wait_cnt   <= '0;
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      pend_valid <= pend_valid_next;
      qty        <= qty_next;
      rx_count   <= rx_count_next;
      wait_cnt   <= wait_cnt_next;
      if (cfg_we) begin
        resp_limit <= cfg_data;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    crc_lo      <= crc_lo_next;
    hdr_id      <= hdr_id_next;
    hdr_fc      <= hdr_fc_next;
    hold_hi     <= hold_hi_next;
    echo_bad    <= echo_bad_next;
    tx_idx      <= tx_idx_next;
    pend_status <= pend_status_next;
    pend_exc    <= pend_exc_next;
    pend_words  <= pend_words_next;
    widx        <= widx_next;
    if (emit) begin
      out_kind       <= e_kind;
      tx_byte        <= e_tx;
      status         <= e_status;
      exception_code <= e_exc;
      reg_word       <= e_word;
      reg_index      <= e_idx;
      last           <= e_last;
    end
    if (load_req) begin
      rq[0] <= slave_addr;
      rq[1] <= func_write ? FC_WRITE : FC_READ;
      rq[2] <= reg_addr[15:8];
      rq[3] <= reg_addr[7:0];
      rq[4] <= word_value[15:8];
      rq[5] <= word_value[7:0];
    end else if (rotate) begin
      rq[0] <= rq[1];
      rq[1] <= rq[2];
      rq[2] <= rq[3];
      rq[3] <= rq[4];
      rq[4] <= rq[5];
      rq[5] <= rq[0];
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store[rx_count[AW:1]] <= {hold_hi, rx_byte};
    end
    rdata <= store[widx[AW-1:0]];
  end

endmodule

`default_nettype wire

/* rtl/core/mbrtu_checker.sv */
// ----------------------------------------------------------------------------
// Modbus RTU master port checker
// Watches the result channel of the transaction block; bound into that block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "modbus_rtu_master_transaction_assert.svh"

module mbrtu_checker
  import mbrtu_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_kind,
  input wire logic [7:0]  tx_byte,
  input wire logic [2:0]  status,
  input wire logic [7:0]  exception_code,
  input wire logic [15:0] reg_word,
  input wire logic [3:0]  reg_index,
  input wire logic        last
);

  `MB_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(tx_byte) && $stable(reg_word) && $stable(last))

  `MB_ASSERT_NOW(a_tx_clean, clk, rst, out_valid && out_kind == KIND_TX, status == STAT_OK && exception_code == 8'h00 && reg_word == 16'h0000 && reg_index == 4'h0)

  `MB_ASSERT_NOW(a_exc_only, clk, rst, out_valid && exception_code != 8'h00, out_kind == KIND_STATUS && status == STAT_EXC)

  `MB_ASSERT_NOW(a_word_clean, clk, rst, out_valid && out_kind == KIND_WORD, status == STAT_OK && tx_byte == 8'h00 && exception_code == 8'h00)

endmodule

bind modbus_rtu_master_transaction mbrtu_checker u_mbrtu_checker (.*);

`default_nettype wire

/* tb/tb_modbus_rtu_master_transaction.sv */
// ----------------------------------------------------------------------------
// Modbus RTU master transaction testbench
// Drives start, reply-byte and tick beats into the block, tracks the
// transaction in a local model, and checks every output beat in order.
// Covers reads, writes, reply errors, exceptions, timeouts and back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_modbus_rtu_master_transaction;
  import mbrtu_pkg::*;

  localparam int NQ = 16;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  tx;
    logic [2:0]  st;
    logic [7:0]  exc;
    logic [15:0] word;
    logic [3:0]  idx;
    logic        lst;
  } mb_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] req_type = '0;
  logic [7:0] slave_addr = '0;
  logic func_write = 1'b0;
  logic [15:0] reg_addr = '0;
  logic [15:0] word_value = '0;
  logic [7:0] rx_byte = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] tx_byte;
  logic [2:0] status;
  logic [7:0] exception_code;
  logic [15:0] reg_word;
  logic [3:0] reg_index;
  logic last;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;

  modbus_rtu_master_transaction u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .slave_addr(slave_addr), .func_write(func_write),
    .reg_addr(reg_addr), .word_value(word_value), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_kind(out_kind), .tx_byte(tx_byte), .status(status),
    .exception_code(exception_code), .reg_word(reg_word),
    .reg_index(reg_index), .last(last),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  mb_result_t pending_results[$];
  mb_result_t staged[$];
  int fails = 0;
  int beats_sent = 0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;

  // transaction tracker
  phase_t      m_phase = PH_IDLE;
  logic [7:0]  m_req[6];
  logic [7:0]  m_qty = '0;
  logic [7:0]  m_cnt = '0;
  logic [15:0] m_crc = CRC_SEED;
  logic [7:0]  m_crclo = '0;
  logic [15:0] m_store[NQ];
  logic [15:0] m_wait = '0;
  logic [7:0]  m_hid = '0;
  logic [7:0]  m_hfc = '0;
  bit          m_ebad = 1'b0;
  logic [15:0] m_timeout = TIMEOUT_RST;

  function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
    c = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic logic [15:0] frame_crc(logic [7:0] f[$]);
    logic [15:0] c;
    c = CRC_SEED;
    foreach (f[i]) c = crc_step(c, f[i]);
    return c;
  endfunction

  function automatic void stage(logic [1:0] k, logic [7:0] tx, logic [2:0] st,
                                logic [7:0] exc, logic [15:0] w, logic [3:0] ix);
    mb_result_t r;
    r.kind = k; r.tx = tx; r.st = st; r.exc = exc; r.word = w; r.idx = ix;
    r.lst = 1'b0;
    staged.push_back(r);
  endfunction

  function automatic void end_status(logic [2:0] st, logic [7:0] exc);
    m_phase = PH_IDLE;
    stage(KIND_STATUS, 8'h00, st, exc, 16'h0000, 4'h0);
  endfunction

  function automatic void track_start(logic [7:0] sa, logic fw, logic [15:0] ra,
                                      logic [15:0] wv);
    logic [15:0] c;
    m_phase = PH_IDLE;
    if (!fw && (wv == 0 || wv > NQ)) begin
      end_status(STAT_BADARG, 8'h00);
      return;
    end
    m_req[0] = sa;
    m_req[1] = fw ? FC_WRITE : FC_READ;
    m_req[2] = ra[15:8];
    m_req[3] = ra[7:0];
    m_req[4] = wv[15:8];
    m_req[5] = wv[7:0];
    c = CRC_SEED;
    for (int i = 0; i < 6; i++) begin
      c = crc_step(c, m_req[i]);
      stage(KIND_TX, m_req[i], STAT_OK, 8'h00, 16'h0000, 4'h0);
    end
    stage(KIND_TX, c[7:0], STAT_OK, 8'h00, 16'h0000, 4'h0);
    stage(KIND_TX, c[15:8], STAT_OK, 8'h00, 16'h0000, 4'h0);
    m_qty = fw ? 8'h00 : wv[7:0];
    m_cnt = '0;
    m_crc = CRC_SEED;
    m_crclo = '0;
    m_wait = '0;
    m_ebad = 1'b0;
    m_phase = fw ? PH_WECHO : PH_RHDR;
  endfunction

  function automatic void track_byte(logic [7:0] b);
    int bc;
    int k;
    bc = 2 * m_qty;
    k = m_cnt;
    case (m_phase)
      PH_RHDR: begin
        m_crc = crc_step(m_crc, b);
        if (k == 0) begin
          m_hid = b; m_cnt = 8'd1;
        end else if (k == 1) begin
          m_hfc = b; m_cnt = 8'd2;
        end else if (m_hid != m_req[0]) end_status(STAT_BADFRAME, 8'h00);
        else if (m_hfc & FC_EXC_BIT) end_status(STAT_EXC, b);
        else if (m_hfc != FC_READ) end_status(STAT_BADFRAME, 8'h00);
        else if (b != bc[7:0]) end_status(STAT_BADFRAME, 8'h00);
        else begin
          m_phase = PH_RBODY; m_cnt = '0; m_wait = '0;
        end
      end
      PH_RBODY: begin
        if (k < bc) begin
          m_crc = crc_step(m_crc, b);
          if ((k >> 1) < NQ) begin
            if (k % 2 == 0) m_store[k >> 1] = {b, 8'h00};
            else m_store[k >> 1][7:0] = b;
          end
          m_cnt++;
        end else if (k == bc) begin
          m_crclo = b; m_cnt++;
        end else if ({b, m_crclo} != m_crc) end_status(STAT_CRC, 8'h00);
        else begin
          end_status(STAT_OK, 8'h00);
          for (int i = 0; i < m_qty && i < NQ; i++)
            stage(KIND_WORD, 8'h00, STAT_OK, 8'h00, m_store[i], i[3:0]);
        end
      end
      PH_WECHO: begin
        if (k < 6) begin
          m_crc = crc_step(m_crc, b);
          if (b != m_req[k]) m_ebad = 1'b1;
          m_cnt++;
        end else if (k == 6) begin
          m_crclo = b; m_cnt = 8'd7;
        end else if ({b, m_crclo} != m_crc) end_status(STAT_CRC, 8'h00);
        else end_status(m_ebad ? STAT_BADFRAME : STAT_OK, 8'h00);
      end
      default: ;
    endcase
  endfunction

  function automatic void track_item(logic [1:0] t, logic [7:0] sa, logic fw,
                                     logic [15:0] ra, logic [15:0] wv, logic [7:0] rb);
    staged.delete();
    if (t == REQ_START) track_start(sa, fw, ra, wv);
    else if (t == REQ_BYTE) track_byte(rb);
    else if (t == REQ_TICK && m_phase != PH_IDLE) begin
      if (m_wait < WAIT_MAX) m_wait++;
      if (m_wait >= m_timeout) end_status(STAT_TIMEOUT, 8'h00);
    end
    if (staged.size() > 0) staged[$].lst = 1'b1;
    foreach (staged[i]) pending_results.push_back(staged[i]);
  endfunction

  function automatic int gap_len();
    if (idle_on && $urandom_range(0, 3) == 0) return $urandom_range(1, 10);
    return 0;
  endfunction

  task automatic send_item(logic [1:0] t, logic [7:0] sa, logic fw,
                           logic [15:0] ra, logic [15:0] wv, logic [7:0] rb);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= t;
    slave_addr <= sa;
    func_write <= fw;
    reg_addr <= ra;
    word_value <= wv;
    rx_byte <= rb;
    do @(posedge clk); while (!in_ready);
    track_item(t, sa, fw, ra, wv, rb);
    beats_sent++;
  endtask

  task automatic send_start(logic [7:0] sa, logic fw, logic [15:0] ra, logic [15:0] wv);
    send_item(REQ_START, sa, fw, ra, wv, 8'($urandom));
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(REQ_BYTE, 8'($urandom), 1'($urandom), 16'($urandom), 16'($urandom), b);
  endtask

  task automatic send_tick();
    send_item(REQ_TICK, 8'($urandom), 1'($urandom), 16'($urandom), 16'($urandom),
              8'($urandom));
  endtask

  task automatic send_frame(logic [7:0] f[$], bit with_crc, bit ticks);
    logic [15:0] c;
    c = frame_crc(f);
    if (with_crc) begin
      f.push_back(c[7:0]);
      f.push_back(c[15:8]);
    end
    foreach (f[i]) begin
      if (ticks && $urandom_range(0, 7) == 0) send_tick();
      send_byte(f[i]);
    end
  endtask

  task automatic drain_and_write(logic [15:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_timeout = v;
  endtask

  function automatic void read_reply(ref logic [7:0] f[$], input logic [7:0] sa,
                                     input int n);
    f = {sa, FC_READ, 8'(2 * n)};
    for (int i = 0; i < 2 * n; i++) f.push_back(8'($urandom));
  endfunction

  task automatic test_directed();
    logic [7:0] f[$];
    drain_and_write(16'hFFFF);
    send_byte(8'hA5);
    send_tick();
    send_item(2'd3, 8'hFF, 1'b1, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_start(8'h01, 1'b0, 16'h0000, 16'h0000);
    send_start(8'hFF, 1'b0, 16'hFFFF, 16'd17);
    send_start(8'h01, 1'b0, 16'hFFFF, 16'hFFFF);
    send_start(8'hFF, 1'b0, 16'hFFFF, 16'd1);
    read_reply(f, 8'hFF, 1);
    send_frame(f, 1'b1, 1'b0);
    send_start(8'h00, 1'b0, 16'h0000, 16'd16);
    f = {8'h00, FC_READ, 8'd32};
    for (int i = 0; i < 32; i++) f.push_back(i[0] ? 8'hFF : 8'h00);
    send_frame(f, 1'b1, 1'b0);
    send_start(8'h11, 1'b1, 16'hFFFF, 16'hFFFF);
    f = {8'h11, FC_WRITE, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_frame(f, 1'b1, 1'b0);
    send_start(8'h11, 1'b1, 16'h0000, 16'h0000);
    f = {8'h11, FC_WRITE, 8'h00, 8'h00, 8'h00, 8'h01};
    send_frame(f, 1'b1, 1'b0);
    send_start(8'h22, 1'b0, 16'h1234, 16'd2);
    send_frame({8'h22, 8'h84, 8'h02}, 1'b0, 1'b0);
    send_byte(8'h00);
    send_start(8'h22, 1'b0, 16'h1234, 16'd2);
    send_frame({8'h23, FC_READ, 8'd4}, 1'b0, 1'b0);
    send_start(8'h22, 1'b0, 16'h1234, 16'd2);
    send_frame({8'h22, FC_WRITE, 8'd4}, 1'b0, 1'b0);
    send_start(8'h22, 1'b0, 16'h1234, 16'd2);
    send_frame({8'h22, FC_READ, 8'd5}, 1'b0, 1'b0);
    send_start(8'h22, 1'b0, 16'h1234, 16'd1);
    send_frame({8'h22, FC_READ, 8'd2, 8'hAB, 8'hCD, 8'h00, 8'h00}, 1'b0, 1'b0);
    send_start(8'h33, 1'b0, 16'h0001, 16'd3);
    send_frame({8'h33, FC_READ}, 1'b0, 1'b0);
    send_start(8'h34, 1'b1, 16'h0002, 16'h0003);
  endtask

  task automatic test_timeout();
    logic [7:0] f[$];
    drain_and_write(16'd2);
    send_start(8'h05, 1'b0, 16'h0010, 16'd2);
    send_tick();
    send_tick();
    send_tick();
    send_start(8'h05, 1'b0, 16'h0010, 16'd1);
    send_tick();
    send_frame({8'h05, FC_READ, 8'd2}, 1'b0, 1'b0);
    send_tick();
    send_tick();
    drain_and_write(16'd1);
    send_start(8'h06, 1'b1, 16'h0010, 16'h0020);
    send_tick();
    send_byte(8'h06);
  endtask

  task automatic random_txn();
    logic [7:0] f[$];
    logic [7:0] sa;
    int n;
    int mode;
    logic [15:0] ra;
    logic [15:0] wv;
    logic [15:0] c;
    sa = 8'($urandom);
    ra = 16'($urandom);
    mode = $urandom_range(0, 11);
    if ($urandom_range(0, 2) == 0) begin
      wv = 16'($urandom);
      send_start(sa, 1'b1, ra, wv);
      f = {sa, FC_WRITE, ra[15:8], ra[7:0], wv[15:8], wv[7:0]};
      if (mode == 6) f[$urandom_range(0, 5)] ^= 8'($urandom_range(1, 255));
      if (mode == 7) begin
        send_frame(f, 1'b1, 1'b1);
        return;
      end
      c = frame_crc(f);
      f.push_back(c[7:0]);
      f.push_back(c[15:8]);
      if (mode == 8) f[$] ^= 8'($urandom_range(1, 255));
      send_frame(f, 1'b0, 1'b1);
      return;
    end
    if (mode == 11) begin
      send_start(sa, 1'b0, ra, $urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom_range(17, 65535)));
      return;
    end
    n = $urandom_range(0, 9) == 0 ? NQ : $urandom_range(1, 4);
    send_start(sa, 1'b0, ra, 16'(n));
    if (mode == 9) begin
      send_frame({sa, 8'(FC_READ | FC_EXC_BIT), 8'($urandom)}, 1'b1, 1'b1);
      return;
    end
    read_reply(f, sa, n);
    if (mode == 6) f[$urandom_range(0, f.size() - 1)] ^= 8'($urandom_range(1, 255));
    if (mode == 10) begin
      for (int i = $urandom_range(0, 5); i > 0; i--) send_byte(8'($urandom));
      return;
    end
    if (mode == 8 && m_timeout <= 8) begin
      send_frame(f[0:$urandom_range(0, f.size() - 1)], 1'b0, 1'b0);
      for (int i = 0; i < m_timeout; i++) send_tick();
      return;
    end
    send_frame(f, 1'b1, 1'b1);
    if (mode == 5) send_byte(8'($urandom));
  endtask

  task automatic test_random(int budget);
    int stop_at;
    stop_at = beats_sent + budget;
    while (beats_sent < stop_at) random_txn();
  endtask

  task automatic test_backpressure();
    logic [7:0] f[$];
    hold_req = 1'b1;
    send_start(8'h44, 1'b0, 16'h00FF, 16'd16);
    read_reply(f, 8'h44, 16);
    send_frame(f, 1'b1, 1'b0);
    send_start(8'h45, 1'b1, 16'h0001, 16'hBEEF);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_timeout();
    drain_and_write(16'd500);
    test_random(35);
    drain_and_write(16'd4);
    test_random(30);
    test_backpressure();
    drain_and_write(16'hFFFF);
    idle_on = 1'b0;
    test_random(35);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fails == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    mb_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected beat kind=%0d tx=%h st=%0d word=%h", $time,
                 out_kind, tx_byte, status, reg_word);
        fails++;
      end else begin
        e = pending_results.pop_front();
        if ({out_kind, tx_byte, status, exception_code, reg_word, reg_index, last} !==
            {e.kind, e.tx, e.st, e.exc, e.word, e.idx, e.lst}) begin
          $display("%0t: expected kind=%0d tx=%h st=%0d exc=%h word=%h idx=%0d last=%b",
                   $time, e.kind, e.tx, e.st, e.exc, e.word, e.idx, e.lst);
          $display("%0t: actual   kind=%0d tx=%h st=%0d exc=%h word=%h idx=%0d last=%b",
                   $time, out_kind, tx_byte, status, exception_code, reg_word,
                   reg_index, last);
          fails++;
        end
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire

/* modbus_rtu_master_transaction.f */
+incdir+rtl/core
rtl/core/mbrtu_pkg.sv
rtl/core/mbrtu_crc.sv
rtl/core/modbus_rtu_master_transaction.sv
rtl/core/mbrtu_checker.sv
tb/tb_modbus_rtu_master_transaction.sv
